FILE: hw/rtl/amb_pkg.sv
package amb_pkg;

	// vertex index width and queue depth follow from the largest graph
	localparam int unsigned VIDX_W = 3;
	localparam int unsigned QDEPTH = 8;
	localparam int unsigned QPTR_W = $clog2(QDEPTH) + 1;
	localparam int unsigned ROW_W  = 8;
	localparam int unsigned NROWS  = 8;

	typedef logic [VIDX_W-1:0] vidx_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [QPTR_W-1:0] qptr_t;

	// search sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEQ,
		ST_SCAN,
		ST_FLUSH
	} state_t;

endpackage

FILE: hw/rtl/amb_if.sv
// start vertex channel
interface amb_req_if;
	import amb_pkg::*;
	logic  valid;
	logic  ready;
	vidx_t start_vertex;
	modport source (output valid, output start_vertex, input ready);
	modport sink (input valid, input start_vertex, output ready);
endinterface

// visit order channel
interface amb_rsp_if;
	import amb_pkg::*;
	logic  valid;
	logic  ready;
	vidx_t vertex;
	logic  last_flag;
	modport source (output valid, output vertex, output last_flag, input ready);
	modport sink (input valid, input vertex, input last_flag, output ready);
endinterface

FILE: hw/rtl/adjacency_matrix_bfs_order.sv
// channel  dir  payload                  handshake
// req      in   start_vertex[2:0]        valid/ready
// rsp      out  vertex[2:0], last_flag   valid/ready
// apb      in   adj_row_0..7 at 4*i      psel/penable/pwrite, pready=1
//
// A query steps through the accept, one dequeue per vertex reached, one
// priority-encode per emitted neighbor and per exhausted row, an empty-queue
// check and a flush; a start beyond the vertex count goes from the accept
// straight to the flush. req.ready is high only while
// the sequencer is idle. Each result is held one step behind so the last one
// can carry last_flag; a stalled rsp channel stalls the scan. Reset clears rows
// and control.
module adjacency_matrix_bfs_order
	import amb_pkg::*;
#(
	parameter int unsigned VERTICES = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	amb_req_if.sink       req,
	amb_rsp_if.source     rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam row_t VMASK = ROW_W'((1 << VERTICES) - 1);

	state_t state_q, state_d;
	row_t   adj_q [NROWS];
	row_t   visited_q;
	qptr_t  head_q, tail_q;
	vidx_t  cur_q, pend_q;
	vidx_t  queue_q [QDEPTH];
	logic   out_valid_q;
	vidx_t  out_vertex_q;
	logic   out_last_q;

	logic   accept, in_range, out_free;
	row_t   cand, pick_oh;
	vidx_t  pick;
	logic   found, adv, deq, flush_go;
	logic   q_we;
	logic [QPTR_W-2:0] q_waddr;
	vidx_t  q_wdata;

	// config port
	assign pready = 1'b1;
	assign prdata = {24'b0, adj_q[paddr[4:2]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NROWS; i++) adj_q[i] <= '0;
		end else if (psel && penable && pwrite && pready) begin
			adj_q[paddr[4:2]] <= pwdata[ROW_W-1:0];
		end
	end

	// lowest unvisited neighbor of the current vertex
	assign cand = adj_q[cur_q] & ~visited_q & VMASK;
	always_comb begin
		pick = '0;
		for (int j = NROWS - 1; j >= 0; j--) begin
			if (cand[j]) pick = VIDX_W'(j);
		end
	end
	assign found   = |cand;
	assign pick_oh = ROW_W'(1) << pick;

	assign accept   = req.valid && req.ready;
	assign in_range = {1'b0, req.start_vertex} < (VIDX_W + 1)'(VERTICES);
	assign out_free = !out_valid_q || rsp.ready;

	// control strobes
	always_comb begin
		adv      = 1'b0;
		deq      = 1'b0;
		flush_go = 1'b0;
		unique case (state_q)
			ST_IDLE:  ;
			ST_DEQ:   deq = (head_q != tail_q);
			ST_SCAN:  adv = found && out_free;
			ST_FLUSH: flush_go = out_free;
			default:  ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (req.valid) state_d = in_range ? ST_DEQ : ST_FLUSH;
			ST_DEQ:   state_d = (head_q != tail_q) ? ST_SCAN : ST_FLUSH;
			ST_SCAN:  if (!found) state_d = ST_DEQ;
			ST_FLUSH: if (flush_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	// queue write port
	always_comb begin
		q_we    = (accept && in_range) || adv;
		q_waddr = accept ? '0 : tail_q[QPTR_W-2:0];
		q_wdata = accept ? req.start_vertex : pick;
	end

	// queue store, registered read into current vertex
	always_ff @(posedge clk) begin
		if (q_we) queue_q[q_waddr] <= q_wdata;
		if (deq) cur_q <= queue_q[head_q[QPTR_W-2:0]];
	end

	// search state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			visited_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
			if (accept) begin
				head_q <= '0;
				if (in_range) begin
					visited_q <= ROW_W'(1) << req.start_vertex;
					tail_q    <= qptr_t'(1);
				end else begin
					visited_q <= '0;
					tail_q    <= '0;
				end
			end
			if (deq) head_q <= head_q + qptr_t'(1);
			if (adv) begin
				visited_q   <= visited_q | pick_oh;
				tail_q      <= tail_q + qptr_t'(1);
				out_valid_q <= 1'b1;
			end
			if (flush_go) out_valid_q <= 1'b1;
		end
	end

	// pending vertex and output payload
	always_ff @(posedge clk) begin
		if (accept) pend_q <= req.start_vertex;
		if (adv) begin
			pend_q       <= pick;
			out_vertex_q <= pend_q;
			out_last_q   <= 1'b0;
		end
		if (flush_go) begin
			out_vertex_q <= pend_q;
			out_last_q   <= 1'b1;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.vertex    = out_vertex_q;
	assign rsp.last_flag = out_last_q;

`ifndef ASSERT_OFF
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_q - head_q) <= qptr_t'(QDEPTH))
		else $error("queue holds more entries than its depth");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> head_q == tail_q)
		else $error("queue not drained at end of query");

	a_visited_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(visited_q) == 32'(tail_q))
		else $error("visited map and enqueued count disagree");

	a_start_pending: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pend_q == $past(req.start_vertex))
		else $error("start vertex not held as first result");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import amb_pkg::*;

	localparam int VERT        = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;
	localparam int IDLE_PCT    = 18;
	localparam int RAND_PHASES = 5;
	localparam int RAND_ITEMS  = 27;

	typedef enum int {
		GR_SPARSE,
		GR_HALF,
		GR_DENSE
	} density_t;

	typedef struct packed {
		vidx_t vertex;
		logic  last_flag;
	} visit_t;

	// Tracks the graph as programmed and predicts the visit order per query
	class bfs_order_board;
		row_t   adj [NROWS];
		visit_t order_q [$];
		int     accepted;
		int     checked;
		int     errors;

		function void note_start(vidx_t s);
			logic [VERT-1:0] seen;
			vidx_t           fifo [$];
			vidx_t           cur;
			accepted++;
			seen = '0;
			seen[s] = 1'b1;
			order_q.push_back('{vertex: s, last_flag: 1'b0});
			if (s < VERT)
				fifo.push_back(s);
			// dequeue, then take unvisited neighbors lowest index first
			while (fifo.size() > 0) begin
				cur = fifo.pop_front();
				for (int j = 0; j < VERT; j++) begin
					if (adj[cur][j] && !seen[j]) begin
						seen[j] = 1'b1;
						order_q.push_back('{vertex: vidx_t'(j), last_flag: 1'b0});
						fifo.push_back(vidx_t'(j));
					end
				end
			end
			order_q[order_q.size()-1].last_flag = 1'b1;
		endfunction

		function void check_visit(vidx_t v, logic lf);
			visit_t want;
			if (order_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: vertex %0d last %0b", v, lf);
				return;
			end
			want = order_q.pop_front();
			checked++;
			if (v !== want.vertex || lf !== want.last_flag) begin
				errors++;
				if (errors <= 10)
					$display("result %0d: expected vertex %0d last %0b, got vertex %0d last %0b",
						checked, want.vertex, want.last_flag, v, lf);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	amb_req_if req_ch ();
	amb_rsp_if rsp_ch ();

	adjacency_matrix_bfs_order DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bfs_order_board bfs_sb;
	vidx_t          start_q [$];
	row_t           graph [NROWS];
	int             pushed;
	int             graphs;
	int             stall_req;
	int             stall_seen;
	int             hold_left;
	int             quiet;
	logic           idle_en;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// start vertex sender
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.start_vertex <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				bfs_sb.note_start(req_ch.start_vertex);
			if (!req_ch.valid || req_ch.ready) begin
				if (start_q.size() > 0 && !(idle_en && $urandom_range(99) < IDLE_PCT)) begin
					req_ch.valid <= 1'b1;
					req_ch.start_vertex <= start_q.pop_front();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// visit order receiver, with an occasional long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= 0;
			stall_seen <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready)
				bfs_sb.check_visit(rsp_ch.vertex, rsp_ch.last_flag);
			if (stall_seen != stall_req) begin
				stall_seen <= stall_req;
				hold_left <= HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// watchdog: cycles with no handshake on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("no item moved for %0d cycles", QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// APB write: setup then access, register updates on the access edge
	task automatic write_row(input int r, input row_t val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(r * 4);
		pwdata <= ($urandom() & 32'hFFFF_FF00) | 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		bfs_sb.adj[r] = val;
	endtask

	task automatic load_graph();
		for (int r = 0; r < NROWS; r++)
			write_row(r, graph[r]);
		graphs++;
	endtask

	task automatic queue_start(input vidx_t s);
		start_q.push_back(s);
		pushed++;
	endtask

	// wait for every query taken and every visit seen, then let the block go idle
	task automatic settle();
		while (bfs_sb.accepted != pushed)
			@(posedge clk);
		while (bfs_sb.order_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic row_t random_row(input density_t d);
		case (d)
			GR_SPARSE: return row_t'($urandom & $urandom & $urandom);
			GR_HALF:   return row_t'($urandom);
			default:   return row_t'($urandom | $urandom);
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.start_vertex = '0;
		rsp_ch.ready = 1'b0;
		idle_en = 1'b1;
		stall_req = 0;
		pushed = 0;
		graphs = 0;
		bfs_sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no edges: every start comes back alone and flagged last
		for (int r = 0; r < NROWS; r++)
			graph[r] = 8'h00;
		load_graph();
		for (int s = 0; s < VERT; s++)
			queue_start(vidx_t'(s));
		settle();

		// complete graph with self loops: visited vertices never repeat
		for (int r = 0; r < NROWS; r++)
			graph[r] = 8'hFF;
		load_graph();
		queue_start(vidx_t'(0));
		queue_start(vidx_t'(3));
		queue_start(vidx_t'(7));
		settle();

		// binary tree with back edges; breadth order differs from depth order here
		graph[0] = 8'b0000_0110;
		graph[1] = 8'b0001_1000;
		graph[2] = 8'b0110_0000;
		graph[3] = 8'b1000_0001;
		graph[4] = 8'b0000_0100;
		graph[5] = 8'b0000_0000;
		graph[6] = 8'b0000_0010;
		graph[7] = 8'b1000_0000;
		load_graph();
		queue_start(vidx_t'(0));
		queue_start(vidx_t'(1));
		queue_start(vidx_t'(2));
		queue_start(vidx_t'(5));
		queue_start(vidx_t'(6));
		queue_start(vidx_t'(7));
		settle();

		// random graphs; one phase without idling, one with a long output stall
		for (int p = 0; p < RAND_PHASES; p++) begin
			idle_en <= (p != 1);
			for (int r = 0; r < NROWS; r++)
				graph[r] = random_row((p == 4) ? density_t'($urandom_range(2))
					: density_t'(p % 3));
			load_graph();
			for (int i = 0; i < RAND_ITEMS; i++)
				queue_start(vidx_t'($urandom_range(VERT - 1)));
			if (p == 3)
				stall_req <= stall_req + 1;
			settle();
		end
		idle_en <= 1'b1;

		if (bfs_sb.order_q.size() != 0) begin
			bfs_sb.errors += bfs_sb.order_q.size();
			$display("%0d expected results never arrived", bfs_sb.order_q.size());
		end
		$display("%0d start vertices, %0d visits checked over %0d graphs, %0d mismatches",
			bfs_sb.accepted, bfs_sb.checked, graphs, bfs_sb.errors);
		$display("graphs: empty, complete with self loops, tree, random sparse to dense;"
			, " output held off %0d cycles once", HOLD_CYCLES);
		if (bfs_sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
